// ===== rtl/shifted_gaussian_depth_profile_top_macros.svh =====
// ----------------------------------------------------------------------------
// Shifted Gaussian depth profile: assertion macros
// Shared assertion forms for the checker of the profile evaluator.
// ----------------------------------------------------------------------------
`ifndef SHIFTED_GAUSSIAN_DEPTH_PROFILE_TOP_MACROS_SVH
`define SHIFTED_GAUSSIAN_DEPTH_PROFILE_TOP_MACROS_SVH

// Check on every edge outside reset
`define SGDP_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) expr) \
    else $error("sgdp assertion failed");

// Check on every edge, reset included
`define SGDP_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) expr) \
    else $error("sgdp assertion failed during reset");

`endif

// ===== rtl/sgdp_pkg.sv =====
// ----------------------------------------------------------------------------
// sgdp_pkg
// Types and constants shared by the profile evaluator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sgdp_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] REG_GRID_START  = 3'd0;
  localparam logic [2:0] REG_GRID_END    = 3'd1;
  localparam logic [2:0] REG_POINT_COUNT = 3'd2;
  localparam logic [2:0] REG_GRID_STEP   = 3'd3;
  localparam logic [2:0] REG_SPREAD      = 3'd4;
  localparam logic [2:0] REG_PEAK_AREA   = 3'd5;
  localparam logic [2:0] REG_PEAK_DEPTH  = 3'd6;
  localparam logic [2:0] REG_BASELINE    = 3'd7;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_CFG = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;

  localparam int STEP_W  = 34;  // signed effective step
  localparam int DEPTH_W = 45;  // signed unsaturated depth
  localparam int DIFF_W  = 46;  // signed depth minus centre

  localparam logic [30:0] INV_SQRT_2PI = 31'd1713444047;

  // round(2^32 * exp(-2^(k-16)))
  localparam int EXP_TERMS = 21;
  localparam logic [31:0] EXP_TAB [EXP_TERMS] = '{
    32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
    32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
    32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
    32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
    32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801,
    32'd483
  };

  typedef struct packed {
    logic signed [31:0]       grid_start;
    logic signed [31:0]       peak_depth;
    logic [30:0]              spread;
    logic [30:0]              peak_area;
    logic [30:0]              baseline;
    logic signed [STEP_W-1:0] step;
    logic                     bad;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               last;
    logic signed [31:0] dsat;
  } side_t;

  typedef struct packed {
    side_t                     side;
    logic signed [DEPTH_W-1:0] depth;
  } qent_t;

endpackage

`default_nettype wire

// ===== rtl/sgdp_cfg.sv =====
// ----------------------------------------------------------------------------
// sgdp_cfg
// Configuration registers and step/count reconciliation by a serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module sgdp_cfg import sgdp_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_wdata,
  output cfg_t             cfg,
  output logic [CNT_W-1:0] count,
  output logic             busy
);

  localparam logic [1:0] SEQ_IDLE = 2'd0;
  localparam logic [1:0] SEQ_LOAD = 2'd1;
  localparam logic [1:0] SEQ_DIV  = 2'd2;
  localparam logic [1:0] SEQ_FIN  = 2'd3;

  logic signed [31:0] grid_start_r, grid_end_r, peak_depth_r;
  logic [10:0]        point_count_r;
  logic [30:0]        grid_step_r, spread_r, peak_area_r, baseline_r;

  logic [1:0]  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [30:0] div_r, div_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic signed [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     bad_r, bad_nxt;

  logic signed [32:0] span;
  logic               span_neg;
  logic [32:0]        span_abs;
  logic [31:0]        trial;
  logic               ge;
  logic signed [STEP_W-1:0] q_s;
  logic [CNT_W-1:0]   pc_clamp;
  logic               cfg_invalid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_start_r  <= 32'sd0;
      grid_end_r    <= 32'sd16384000;
      point_count_r <= 11'd0;
      grid_step_r   <= 31'd65536;
      spread_r      <= 31'd655360;
      peak_area_r   <= 31'd0;
      peak_depth_r  <= 32'sd0;
      baseline_r    <= 31'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_START:  grid_start_r  <= cfg_wdata;
        REG_GRID_END:    grid_end_r    <= cfg_wdata;
        REG_POINT_COUNT: point_count_r <= cfg_wdata[10:0];
        REG_GRID_STEP:   grid_step_r   <= cfg_wdata[30:0];
        REG_SPREAD:      spread_r      <= cfg_wdata[30:0];
        REG_PEAK_AREA:   peak_area_r   <= cfg_wdata[30:0];
        REG_PEAK_DEPTH:  peak_depth_r  <= cfg_wdata;
        REG_BASELINE:    baseline_r    <= cfg_wdata[30:0];
      endcase
    end
  end

  assign span     = 33'(grid_end_r) - 33'(grid_start_r);
  assign span_neg = span[32];
  assign span_abs = span_neg ? 33'(-span) : 33'(span);
  assign trial    = {rem_r, quo_r[31]};
  assign ge       = trial >= {1'b0, div_r};
  assign q_s      = span_neg ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
  assign pc_clamp = (32'(point_count_r) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                           : CNT_W'(point_count_r);
  assign cfg_invalid = (spread_r == 31'd0) ||
                       (point_count_r == 11'd0 && grid_step_r == 31'd0);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    step_nxt  = step_r;
    count_nxt = count_r;
    bad_nxt   = bad_r;
    unique case (state_r)
      SEQ_IDLE: begin
      end
      SEQ_LOAD: begin
        div_nxt   = (point_count_r != 11'd0) ? 31'(point_count_r) : grid_step_r;
        rem_nxt   = 31'd0;
        quo_nxt   = span_abs[31:0];
        cnt_nxt   = 5'd0;
        state_nxt = cfg_invalid ? SEQ_FIN : SEQ_DIV;
      end
      SEQ_DIV: begin
        rem_nxt = ge ? 31'(trial - {1'b0, div_r}) : trial[30:0];
        quo_nxt = {quo_r[30:0], ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = SEQ_FIN;
      end
      SEQ_FIN: begin
        state_nxt = SEQ_IDLE;
        bad_nxt   = cfg_invalid;
        step_nxt  = STEP_W'(grid_step_r);
        count_nxt = pc_clamp;
        if (!cfg_invalid) begin
          priority if (point_count_r != 11'd0 && grid_step_r != 31'd0) begin
            bad_nxt = q_s != $signed(STEP_W'(grid_step_r));
          end else if (point_count_r != 11'd0) begin
            step_nxt = q_s;
          end else begin
            priority if (q_s < 0)
              count_nxt = '0;
            else if (q_s > $signed(STEP_W'(MAX_POINTS)))
              count_nxt = CNT_W'(MAX_POINTS);
            else
              count_nxt = CNT_W'(q_s);
          end
        end
      end
    endcase
    // restart on any write
    if (cfg_we) state_nxt = SEQ_LOAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_LOAD;
      cnt_r   <= 5'd0;
      step_r  <= '0;
      count_r <= '0;
      bad_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
      count_r <= count_nxt;
      bad_r   <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy  = state_r != SEQ_IDLE;
  assign count = count_r;

  always_comb begin
    cfg.grid_start = grid_start_r;
    cfg.peak_depth = peak_depth_r;
    cfg.spread     = spread_r;
    cfg.peak_area  = peak_area_r;
    cfg.baseline   = baseline_r;
    cfg.step       = step_r;
    cfg.bad        = bad_r;
  end

endmodule

`default_nettype wire

// ===== rtl/sgdp_front.sv =====
// ----------------------------------------------------------------------------
// sgdp_front
// Classify a request by status and compute its grid depth.
// ----------------------------------------------------------------------------
`default_nettype none

module sgdp_front import sgdp_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [9:0]       point_index,
  input  cfg_t             cfg,
  input  logic [CNT_W-1:0] count,
  output logic             push,
  output qent_t            ent
);

  logic        v1_r, v2_r, v3_r;
  logic [9:0]  idx1_r;
  side_t       side1_r, side2_r;
  logic signed [DEPTH_W-1:0] prod2_r;
  logic signed [DEPTH_W-1:0] depth;
  qent_t       ent3_r;
  logic [1:0]  status;

  always_comb begin
    priority if (cfg.bad)
      status = STAT_BAD_CFG;
    else if (32'(point_index) >= 32'(count))
      status = STAT_RANGE;
    else
      status = STAT_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign depth = DEPTH_W'(cfg.grid_start) + prod2_r;

  always_ff @(posedge clk) begin
    idx1_r         <= point_index;
    side1_r.status <= status;
    side1_r.last   <= (status == STAT_OK) && (32'(point_index) + 32'd1 == 32'(count));
    side1_r.dsat   <= 32'sd0;
    prod2_r        <= $signed({1'b0, idx1_r}) * cfg.step;
    side2_r        <= side1_r;
    ent3_r.side.status <= side2_r.status;
    ent3_r.side.last   <= side2_r.last;
    priority if (depth > $signed(DEPTH_W'(32'h7FFF_FFFF)))
      ent3_r.side.dsat <= 32'sh7FFF_FFFF;
    else if (depth < -$signed(DEPTH_W'(33'h0_8000_0000)))
      ent3_r.side.dsat <= 32'sh8000_0000;
    else
      ent3_r.side.dsat <= depth[31:0];
    ent3_r.depth <= depth;
  end

  assign push = v3_r;
  assign ent  = ent3_r;

endmodule

`default_nettype wire

// ===== rtl/sgdp_fifo.sv =====
// ----------------------------------------------------------------------------
// sgdp_fifo
// Short queue between the front and the evaluation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module sgdp_fifo import sgdp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t din,
  output logic  valid,
  output qent_t dout
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  qent_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   fill_r;
  logic             pop;

  // drain whenever something is held
  assign pop   = fill_r != '0;
  assign valid = pop;
  assign dout  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      fill_r <= fill_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= din;
  end

endmodule

`default_nettype wire

// ===== rtl/sgdp_back.sv =====
// ----------------------------------------------------------------------------
// sgdp_back
// Pipelined Gaussian evaluation: divide, square, exp product chain, scale.
// ----------------------------------------------------------------------------
`default_nettype none

module sgdp_back import sgdp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  qent_t              ent,
  input  cfg_t               cfg,
  output logic               out_valid,
  output logic signed [31:0] depth_out,
  output logic signed [31:0] profile_value,
  output logic [1:0]         status,
  output logic               last_point
);

  localparam int U_W    = 19;  // quotient bits of the normalised distance
  localparam int D_W    = 50;
  localparam int T_W    = 21;
  localparam int TERM_W = 31;
  localparam int P_W    = 46;

  // distance stage
  logic               v0_r, v1_r;
  side_t              side0_r, side1_r;
  logic [DIFF_W-1:0]  absd0_r;
  logic signed [DIFF_W-1:0] diff;
  logic               far1_r;
  logic [D_W-1:0]     d1_r;

  assign diff = DIFF_W'(ent.depth) - DIFF_W'(cfg.peak_depth);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    side0_r <= ent.side;
    absd0_r <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    side1_r <= side0_r;
    far1_r  <= absd0_r >= DIFF_W'({cfg.spread, 3'b000});
    d1_r    <= {absd0_r[D_W-17:0], 16'b0};
  end

  // first divider: u = (|diff| << 16) / spread, one quotient bit per stage
  logic           vd [U_W+1];
  side_t          sd [U_W+1];
  logic           fd [U_W+1];
  logic [D_W-1:0] rd [U_W+1];
  logic [U_W-1:0] qd [U_W+1];

  assign vd[0] = v1_r;
  assign sd[0] = side1_r;
  assign fd[0] = far1_r;
  assign rd[0] = d1_r;
  assign qd[0] = '0;

  for (genvar k = 0; k < U_W; k++) begin : g_div_u
    localparam int B = U_W - 1 - k;
    logic [D_W-1:0] sh;
    logic           ge;
    assign sh = D_W'(cfg.spread) << B;
    assign ge = rd[k] >= sh;
    always_ff @(posedge clk) begin
      if (!rst_n) vd[k+1] <= 1'b0;
      else        vd[k+1] <= vd[k];
    end
    always_ff @(posedge clk) begin
      sd[k+1] <= sd[k];
      fd[k+1] <= fd[k];
      rd[k+1] <= ge ? rd[k] - sh : rd[k];
      qd[k+1] <= qd[k] | (U_W'(ge) << B);
    end
  end

  // square
  logic           vs_r;
  side_t          ss_r;
  logic           fs_r;
  logic [T_W-1:0] ts_r;
  logic [2*U_W-1:0] usq;

  assign usq = (2*U_W)'(qd[U_W]) * (2*U_W)'(qd[U_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) vs_r <= 1'b0;
    else        vs_r <= vd[U_W];
  end

  always_ff @(posedge clk) begin
    ss_r <= sd[U_W];
    fs_r <= fd[U_W];
    ts_r <= usq[2*U_W-1:17];
  end

  // exp(-t) as a product over the set bits of t
  logic           ve [EXP_TERMS+1];
  side_t          se [EXP_TERMS+1];
  logic [T_W-1:0] te [EXP_TERMS+1];
  logic [32:0]    ae [EXP_TERMS+1];

  assign ve[0] = vs_r;
  assign se[0] = ss_r;
  assign te[0] = ts_r;
  assign ae[0] = fs_r ? 33'd0 : 33'h1_0000_0000;

  for (genvar k = 0; k < EXP_TERMS; k++) begin : g_exp
    logic [64:0] mul;
    assign mul = 65'(ae[k]) * 65'(EXP_TAB[k]) + 65'h0_8000_0000;
    always_ff @(posedge clk) begin
      if (!rst_n) ve[k+1] <= 1'b0;
      else        ve[k+1] <= ve[k];
    end
    always_ff @(posedge clk) begin
      se[k+1] <= se[k];
      te[k+1] <= te[k];
      ae[k+1] <= te[k][k] ? mul[64:32] : ae[k];
    end
  end

  // scale by 1/sqrt(2 pi), then by the area
  logic            va_r, vp_r, vq_r;
  side_t           sa_r, sp_r, sq_r;
  logic [30:0]     a_r;
  logic [61:0]     p_r;
  logic [63:0]     ma;
  logic [P_W-1:0]  pq_r;
  logic            sat_r;

  assign ma = 64'(ae[EXP_TERMS]) * 64'(INV_SQRT_2PI) + 64'h8000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vp_r <= 1'b0;
      vq_r <= 1'b0;
    end else begin
      va_r <= ve[EXP_TERMS];
      vp_r <= va_r;
      vq_r <= vp_r;
    end
  end

  always_ff @(posedge clk) begin
    sa_r  <= se[EXP_TERMS];
    a_r   <= ma[62:32];
    sp_r  <= sa_r;
    p_r   <= 62'(cfg.peak_area) * 62'(a_r);
    sq_r  <= sp_r;
    pq_r  <= p_r[61:16];
    sat_r <= 62'(p_r[61:16]) >= {cfg.spread, 31'b0};
  end

  // second divider: term = (p >> 16) / spread
  logic              vt [TERM_W+1];
  side_t             st [TERM_W+1];
  logic              xt [TERM_W+1];
  logic [P_W-1:0]    rt [TERM_W+1];
  logic [TERM_W-1:0] qt [TERM_W+1];

  assign vt[0] = vq_r;
  assign st[0] = sq_r;
  assign xt[0] = sat_r;
  assign rt[0] = pq_r;
  assign qt[0] = '0;

  for (genvar k = 0; k < TERM_W; k++) begin : g_div_t
    localparam int B = TERM_W - 1 - k;
    logic [61:0] sh;
    logic        ge;
    assign sh = 62'(cfg.spread) << B;
    assign ge = 62'(rt[k]) >= sh;
    always_ff @(posedge clk) begin
      if (!rst_n) vt[k+1] <= 1'b0;
      else        vt[k+1] <= vt[k];
    end
    always_ff @(posedge clk) begin
      st[k+1] <= st[k];
      xt[k+1] <= xt[k];
      rt[k+1] <= ge ? rt[k] - sh[P_W-1:0] : rt[k];
      qt[k+1] <= qt[k] | (TERM_W'(ge) << B);
    end
  end

  // add the baseline, saturate, zero on error
  logic [31:0] sum;
  logic        ok;
  logic        ov_r;
  logic signed [31:0] depth_r, value_r;
  logic [1:0]  status_r;
  logic        last_r;

  assign sum = 32'(cfg.baseline) + 32'(qt[TERM_W]);
  assign ok  = st[TERM_W].status == STAT_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r     <= 1'b0;
      status_r <= STAT_OK;
      last_r   <= 1'b0;
      depth_r  <= 32'sd0;
      value_r  <= 32'sd0;
    end else begin
      ov_r     <= vt[TERM_W];
      status_r <= st[TERM_W].status;
      last_r   <= ok && st[TERM_W].last;
      depth_r  <= ok ? st[TERM_W].dsat : 32'sd0;
      priority if (!ok)
        value_r <= 32'sd0;
      else if (xt[TERM_W] || sum[31])
        value_r <= 32'sh7FFF_FFFF;
      else
        value_r <= $signed(sum);
    end
  end

  assign out_valid     = ov_r;
  assign depth_out     = depth_r;
  assign profile_value = value_r;
  assign status        = status_r;
  assign last_point    = last_r;

endmodule

`default_nettype wire

// ===== rtl/shifted_gaussian_depth_profile_top.sv =====
// ----------------------------------------------------------------------------
// shifted_gaussian_depth_profile_top
// Evaluates depth and shifted Gaussian profile value at a grid point index.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Handshake
//  -------   -------------------------------------   ---------------------------
//  request   in_point_index                          start high, busy low
//  result    out_depth_out, out_profile_value,       out_valid for one cycle,
//            out_status, out_last_point              cannot be held off
//  config    cfg_index, cfg_wdata                    cfg_we high, no wait
//
//  One request is taken every cycle while busy is low; each gives one result
//  whose strobe rises after the three front stages, the queue, the two
//  bit-per-stage dividers and the 21-stage exponential chain.
//  After reset, and after every configuration write, busy is high while a
//  serial divider reconciles grid step and point count.
//  Results leave on a strobe; the receiver cannot stall the pipeline.
//
`default_nettype none

module shifted_gaussian_depth_profile_top import sgdp_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [9:0]         in_point_index,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output logic               out_valid,
  output logic signed [31:0] out_depth_out,
  output logic signed [31:0] out_profile_value,
  output logic [1:0]         out_status,
  output logic               out_last_point
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  cfg_t             cfg;
  logic [CNT_W-1:0] count;
  logic             accept;
  logic             push;
  qent_t            front_ent;
  logic             q_valid;
  qent_t            q_ent;

  // take a request only once the derived grid is settled
  assign accept = start && !busy;

  // registers plus the step/count reconciliation
  sgdp_cfg #(.MAX_POINTS(MAX_POINTS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .count     (count),
    .busy      (busy)
  );

  // classify the request and form its depth
  sgdp_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .point_index (in_point_index),
    .cfg         (cfg),
    .count       (count),
    .push        (push),
    .ent         (front_ent)
  );

  // decouple front and back
  sgdp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (front_ent),
    .valid (q_valid),
    .dout  (q_ent)
  );

  // evaluate the Gaussian term and drive the result
  sgdp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (q_valid),
    .ent           (q_ent),
    .cfg           (cfg),
    .out_valid     (out_valid),
    .depth_out     (out_depth_out),
    .profile_value (out_profile_value),
    .status        (out_status),
    .last_point    (out_last_point)
  );

endmodule

`default_nettype wire

// ===== rtl/sgdp_checker.sv =====
// ----------------------------------------------------------------------------
// sgdp_checker
// Port-level checks of the profile evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "shifted_gaussian_depth_profile_top_macros.svh"

module sgdp_checker import sgdp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        cfg_we,
  input logic        out_valid,
  input logic [31:0] out_depth_out,
  input logic [31:0] out_profile_value,
  input logic [1:0]  out_status,
  input logic        out_last_point
);

  logic err_zero;

  // all payload cleared on an error result
  assign err_zero = out_depth_out == 32'd0 && out_profile_value == 32'd0 && !out_last_point;

  `SGDP_ASSERT(a_status_code, out_valid |-> out_status <= STAT_RANGE)
  `SGDP_ASSERT(a_error_zero, (out_valid && out_status != STAT_OK) |-> err_zero)
  `SGDP_ASSERT(a_value_positive, out_valid |-> !out_profile_value[31])
  `SGDP_ASSERT(a_write_busy, cfg_we |=> busy)
  `SGDP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid)

endmodule

bind shifted_gaussian_depth_profile_top sgdp_checker u_sgdp_checker (.*);

`default_nettype wire

// ===== sim/shifted_gaussian_depth_profile_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shifted Gaussian depth profile testbench
// Writes grid and peak settings through the register port, sends point
// index requests with random gaps and compares every strobed result with
// a bit-exact fixed-point model kept in a scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module shifted_gaussian_depth_profile_top_tb;
  import sgdp_pkg::*;

  typedef struct {
    logic signed [31:0] depth;
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               last;
  } point_result_t;

  // Scoreboard: holds its own copy of the registers and the results owed
  class profile_scoreboard;
    bit signed [31:0] grid_start, grid_end, peak_depth;
    bit [10:0]        point_count;
    bit [30:0]        grid_step, spread, peak_area, baseline;
    point_result_t    owed[$];
    int               fails;

    function new();
      grid_start = 0; grid_end = 32'sd16384000; point_count = 0;
      grid_step = 31'd65536; spread = 31'd655360; peak_area = 0;
      peak_depth = 0; baseline = 0; fails = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_GRID_START:  grid_start  = v;
        REG_GRID_END:    grid_end    = v;
        REG_POINT_COUNT: point_count = v[10:0];
        REG_GRID_STEP:   grid_step   = v[30:0];
        REG_SPREAD:      spread      = v[30:0];
        REG_PEAK_AREA:   peak_area   = v[30:0];
        REG_PEAK_DEPTH:  peak_depth  = v;
        REG_BASELINE:    baseline    = v[30:0];
        default: ;
      endcase
    endfunction

    // Evaluate one grid point in the block's fixed-point arithmetic
    function point_result_t eval_point(logic [9:0] idx);
      longint start_v, span, step_v, count_v, depth, diff;
      longint unsigned absd, u, t, acc, a, term, val, sp;
      point_result_t r;
      start_v = longint'(grid_start);
      span = longint'(grid_end) - start_v;
      step_v = 0; count_v = 0;
      r.status = STAT_OK; r.depth = 0; r.value = 0; r.last = 0;
      if (spread == 0) begin
        r.status = STAT_BAD_CFG;
      end else if (point_count != 0 && grid_step != 0) begin
        if (span / longint'(point_count) != longint'(grid_step)) r.status = STAT_BAD_CFG;
        step_v = longint'(grid_step);
        count_v = longint'(point_count);
      end else if (point_count != 0) begin
        count_v = longint'(point_count);
        step_v = span / count_v;
      end else if (grid_step != 0) begin
        step_v = longint'(grid_step);
        count_v = span / step_v;
        if (count_v < 0) count_v = 0;
      end else begin
        r.status = STAT_BAD_CFG;
      end
      if (count_v > 1024) count_v = 1024;
      if (r.status == STAT_OK && longint'(idx) >= count_v) r.status = STAT_RANGE;
      if (r.status != STAT_OK) return r;
      depth = start_v + longint'(idx) * step_v;
      diff = depth - longint'(peak_depth);
      absd = diff < 0 ? longint'(-diff) : diff;
      sp = longint'(spread);
      u = (absd << 16) / sp;
      acc = 0;
      if (u < (64'd8 << 16)) begin
        t = (u * u) >> 17;
        acc = 64'd1 << 32;
        for (int k = 0; k < EXP_TERMS; k++)
          if (t[k]) acc = (acc * longint'(EXP_TAB[k]) + (64'd1 << 31)) >> 32;
      end
      a = (acc * longint'(INV_SQRT_2PI) + (64'd1 << 31)) >> 32;
      term = (longint'(peak_area) * a) / (sp << 16);
      val = longint'(baseline) + term;
      if (val > 64'd2147483647) val = 64'd2147483647;
      if (depth > 64'sd2147483647) depth = 64'sd2147483647;
      if (depth < -64'sd2147483648) depth = -64'sd2147483648;
      r.depth = depth[31:0];
      r.value = val[31:0];
      r.last = (longint'(idx) == count_v - 1);
      return r;
    endfunction

    function void note_request(logic [9:0] idx);
      owed.push_back(eval_point(idx));
    endfunction

    function void check_result(logic signed [31:0] depth, logic signed [31:0] value,
                               logic [1:0] status, logic last);
      point_result_t e;
      if (owed.size() == 0) begin
        $display("%0t: result with none owed: depth %0d value %0d status %0d",
                 $time, depth, value, status);
        fails++;
        return;
      end
      e = owed.pop_front();
      if (status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        fails++;
      end
      if (depth !== e.depth) begin
        $display("%0t: depth expected %0d actual %0d", $time, e.depth, depth);
        fails++;
      end
      if (value !== e.value) begin
        $display("%0t: value expected %0d actual %0d", $time, e.value, value);
        fails++;
      end
      if (last !== e.last) begin
        $display("%0t: last_point expected %0d actual %0d", $time, e.last, last);
        fails++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  logic [9:0]         in_point_index = 0;
  logic               cfg_we = 0;
  logic [2:0]         cfg_index = 0;
  logic [31:0]        cfg_wdata = 0;
  logic               out_valid;
  logic signed [31:0] out_depth_out, out_profile_value;
  logic [1:0]         out_status;
  logic               out_last_point;

  profile_scoreboard sb = new();
  int                quiet_cycles = 0;
  int                span_pts;
  bit                no_gaps;

  localparam int QUIET_LIMIT = 3000;

  always #5 clk = ~clk;

  shifted_gaussian_depth_profile_top u_top (
    .clk, .rst_n, .start, .busy, .in_point_index,
    .cfg_we, .cfg_index, .cfg_wdata,
    .out_valid, .out_depth_out, .out_profile_value, .out_status, .out_last_point
  );

  // Check every strobed result against the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_result(out_depth_out, out_profile_value, out_status, out_last_point);
  end

  // Watchdog: reset the count on any request taken or result seen
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one request; hold start high across back-to-back requests
  task automatic send_point(logic [9:0] idx);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_point_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(idx);
  endtask

  // Drop start and wait for every owed result before touching registers
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] gs, logic [31:0] ge, logic [31:0] pc,
                           logic [31:0] st, logic [31:0] sp, logic [31:0] pa,
                           logic [31:0] pd, logic [31:0] bl);
    drain_results();
    write_reg(REG_GRID_START, gs);
    write_reg(REG_GRID_END, ge);
    write_reg(REG_POINT_COUNT, pc);
    write_reg(REG_GRID_STEP, st);
    write_reg(REG_SPREAD, sp);
    write_reg(REG_PEAK_AREA, pa);
    write_reg(REG_PEAK_DEPTH, pd);
    write_reg(REG_BASELINE, bl);
  endtask

  // Random settings, mostly a consistent grid around a peak
  task automatic random_setting();
    int s0, len, stp, md;
    logic [31:0] pc, st, e0;
    md = $urandom_range(0, 9);
    s0 = (int'($urandom_range(0, 2000)) - 1000) * 65536 + int'($urandom_range(0, 65535));
    len = $urandom_range(1, (md == 2) ? 2047 : 1100);
    stp = $urandom_range(1, 4 * 65536);
    e0 = s0 + len * stp + int'($urandom_range(0, stp - 1));
    pc = 0; st = stp;
    if (md >= 6 && md <= 7) begin
      pc = len; st = 0;
    end else if (md == 8) begin
      pc = len; st = 32'((longint'($signed(e0)) - s0) / len);
    end
    span_pts = (len > 1020) ? 1020 : len;
    if (md == 9)
      write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
    else
      write_all(s0, e0, pc, st,
                $urandom_range(1 << 10, 300 << 16),
                ($urandom_range(0, 3) == 0) ? 32'h7fffffff : $urandom,
                s0 + int'($urandom_range(0, len)) * stp,
                ($urandom_range(0, 7) == 0) ? 32'hffffffff : $urandom_range(0, 1 << 20));
  endtask

  initial begin
    int total;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    no_gaps = 0;

    // Reset values: 250 points, step 1.0, zero area
    send_point(10'd0);
    send_point(10'd1);
    send_point(10'd249);
    send_point(10'd250);
    send_point(10'd1023);

    // Derived step, peak inside the grid
    write_all(-32'sd655360, 32'sd6553600, 100, 0, 5 << 16, 50 << 16, 40 << 16, 6554);
    send_point(10'd0);
    send_point(10'd50);
    send_point(10'd99);
    send_point(10'd100);

    // Count and step agreeing, then disagreeing
    write_all(0, 10 << 16, 10, 1 << 16, 1 << 16, 32'h7fffffff, 5 << 16, 0);
    send_point(10'd5);
    send_point(10'd9);
    write_all(0, 10 << 16, 10, 2 << 16, 1 << 16, 32'h7fffffff, 5 << 16, 0);
    send_point(10'd5);

    // Zero spread, then count and step both zero
    write_all(0, 10 << 16, 10, 0, 0, 1 << 16, 0, 0);
    send_point(10'd3);
    write_all(0, 10 << 16, 0, 0, 1 << 16, 1 << 16, 0, 0);
    send_point(10'd3);

    // Full range grid, count saturated at 1024, value saturated
    write_all(32'h80000000, 32'h7fffffff, 2047, 0, 32'h7fffffff, 32'h7fffffff,
              32'h80000000, 32'h7fffffff);
    send_point(10'd0);
    send_point(10'd1023);
    write_all(32'h80000000, 32'h7fffffff, 0, 1 << 16, 1 << 10, 32'h7fffffff, 0, 0);
    send_point(10'd1023);
    send_point(10'd512);

    // Negative span with derived count
    write_all(10 << 16, 0, 0, 1 << 16, 1 << 16, 1 << 16, 0, 0);
    send_point(10'd0);

    total = 0;
    while (total < 1550) begin
      random_setting();
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 120; n++) begin
        if ($urandom_range(0, 9) == 0) send_point(10'($urandom_range(0, 1023)));
        else send_point(10'($urandom_range(0, span_pts + 3)));
        total++;
      end
    end

    drain_results();
    repeat (150) @(posedge clk);
    if (sb.fails == 0 && sb.owed.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
